@@ rtl/ctpm_pkg.sv @@
// Package for the camera trigger part matcher: sizes, register codes and shared types.
package ctpm_pkg;

  localparam int CAMERAS            = 5;
  localparam int ENTRIES_PER_CAMERA = 16;

  localparam int CAM_W   = (CAMERAS > 1) ? $clog2(CAMERAS) : 1;
  localparam int IDX_W   = $clog2(ENTRIES_PER_CAMERA);
  localparam int CNT_W   = $clog2(ENTRIES_PER_CAMERA + 1);
  localparam int RES_W   = $clog2(CAMERAS + 1);
  localparam int ADDR_W  = CAM_W + IDX_W;
  localparam int RAM_DEPTH = CAMERAS * (2 ** IDX_W);

  localparam logic [15:0] SEARCH_LIMIT   = 16'd60000;
  localparam logic [15:0] WINDOW_RESET   = 16'd5000;
  localparam logic [19:0] MARGIN_RESET   = 20'd5000;

  // Configuration register indexes
  localparam logic [2:0] REG_OFFSET_CAM0   = 3'd0;
  localparam logic [2:0] REG_OFFSET_CAM4   = 3'd4;
  localparam logic [2:0] REG_MATCH_WINDOW  = 3'd5;
  localparam logic [2:0] REG_EXPIRY_MARGIN = 3'd6;

  // Sequencer states
  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_PREP   = 7'b0000010,
    ST_KADD   = 7'b0000100,
    ST_SCAN   = 7'b0001000,
    ST_PURGE  = 7'b0010000,
    ST_APPEND = 7'b0100000,
    ST_EMIT   = 7'b1000000
  } state_t;

  typedef struct packed {
    logic [2:0]  cam;
    logic [31:0] pos;
  } result_t;

endpackage

@@ rtl/ctpm_ram.sv @@
// Generic simple dual-port RAM with registered read.
module ctpm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one word, read one word a cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ rtl/camera_trigger_part_matcher.sv @@
// Top level of the camera trigger part matcher: sequencer, shared adder and part table.
//
//  channel | dir | handshake          | payload
//  in_     | in  | in_tvalid/tready   | tdata: encoder_pos, latch_value, trigger_bits; tuser: latch_seen
//  out_    | out | out_tvalid/tready  | tdata: camera_index, matched_position; tlast: last
//  cfg_    | in  | cfg_valid/ready    | cfg_index, cfg_data
//
// A poll runs per camera the setup states PREP and KADD, a search pass over the stored
// entries on a falling trigger, a purge pass over them and the append state; each pass
// reads the entries one at a time through the single RAM read port and the shared
// adders and compare used for every entry.
// Then one cycle per result, stalled while out_tready is low; in_tready is low meanwhile.
// Reset (rst_n, synchronous) empties all tables at once through per-camera fill counts.
module camera_trigger_part_matcher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // [31:0] encoder_pos, [63:32] latch_value, [68:64] trigger_bits
  input  logic        in_tuser,   // [0] latch_seen
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [2:0] camera_index, [34:3] matched_position
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int C = ctpm_pkg::CAMERAS;
  localparam int E = ctpm_pkg::ENTRIES_PER_CAMERA;

  ctpm_pkg::state_t state_r, state_nxt;

  logic [31:0] offset_r [C];
  logic [15:0] window_r;
  logic [19:0] margin_r;

  logic [C-1:0]                  prev_trig_r;
  logic [C-1:0]                  fall_r;
  logic [31:0]                   latch_r;
  logic                          changed_r;
  logic [31:0]                   cur_r;
  logic [ctpm_pkg::CNT_W-1:0]    cnt_r [C];
  logic [ctpm_pkg::CAM_W-1:0]    cam_r;
  logic [31:0]                   k_r, k2_r;
  logic [ctpm_pkg::CNT_W-1:0]    rd_idx_r, w_idx_r;
  logic                          pv_r;
  logic [15:0]                   best_r;
  logic [31:0]                   best_val_r;
  logic                          found_r;
  ctpm_pkg::result_t             res_r [C];
  logic [ctpm_pkg::RES_W-1:0]    res_cnt_r, emit_r;

  logic [31:0]                   rd_data;
  logic                          wr_en;
  logic [ctpm_pkg::ADDR_W-1:0]   wr_addr, rd_addr;
  logic [31:0]                   wr_data;
  logic [ctpm_pkg::CNT_W-1:0]    cnt_cur;
  logic                          rd_go, pass_done;
  logic [31:0]                   diff, mag, slack;
  logic                          drop, last_cam;

  assign in_tready = (state_r == ctpm_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;
  assign cnt_cur   = cnt_r[cam_r];
  assign rd_go     = (rd_idx_r < cnt_cur);
  assign pass_done = !rd_go && !pv_r;
  assign last_cam  = (cam_r == ctpm_pkg::CAM_W'(C - 1));

  // Shared datapath: distance of the entry just read
  assign diff  = rd_data + k_r;
  assign mag   = diff[31] ? (32'd0 - diff) : diff;
  assign slack = rd_data + k2_r;
  assign drop  = (found_r && (rd_data == best_val_r)) || slack[31];

  // Table port control
  assign rd_addr = {cam_r, rd_idx_r[ctpm_pkg::IDX_W-1:0]};
  assign wr_addr = {cam_r, w_idx_r[ctpm_pkg::IDX_W-1:0]};
  always_comb begin
    wr_en   = 1'b0;
    wr_data = rd_data;
    if (state_r == ctpm_pkg::ST_PURGE) begin
      wr_en = pv_r && !drop;
    end else if (state_r == ctpm_pkg::ST_APPEND) begin
      wr_en   = changed_r && (w_idx_r < ctpm_pkg::CNT_W'(E));
      wr_data = latch_r;
    end
  end

  ctpm_ram #(
    .WIDTH(32),
    .DEPTH(ctpm_pkg::RAM_DEPTH)
  ) u_table (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ctpm_pkg::ST_IDLE:   if (in_tvalid) state_nxt = ctpm_pkg::ST_PREP;
      ctpm_pkg::ST_PREP:   state_nxt = ctpm_pkg::ST_KADD;
      ctpm_pkg::ST_KADD:   state_nxt = fall_r[cam_r] ? ctpm_pkg::ST_SCAN : ctpm_pkg::ST_PURGE;
      ctpm_pkg::ST_SCAN:   if (pass_done) state_nxt = ctpm_pkg::ST_PURGE;
      ctpm_pkg::ST_PURGE:  if (pass_done) state_nxt = ctpm_pkg::ST_APPEND;
      ctpm_pkg::ST_APPEND: begin
        if (!last_cam) state_nxt = ctpm_pkg::ST_PREP;
        else if (res_cnt_r != '0) state_nxt = ctpm_pkg::ST_EMIT;
        else state_nxt = ctpm_pkg::ST_IDLE;
      end
      ctpm_pkg::ST_EMIT: begin
        if (out_tready && (emit_r == res_cnt_r - 1'b1)) state_nxt = ctpm_pkg::ST_IDLE;
      end
      default: state_nxt = ctpm_pkg::ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ctpm_pkg::ST_IDLE;
      prev_trig_r <= '0;
      latch_r     <= '0;
      window_r    <= ctpm_pkg::WINDOW_RESET;
      margin_r    <= ctpm_pkg::MARGIN_RESET;
      for (int i = 0; i < C; i++) begin
        offset_r[i] <= '0;
        cnt_r[i]    <= '0;
      end
      cam_r     <= '0;
      pv_r      <= 1'b0;
      res_cnt_r <= '0;
      emit_r    <= '0;
    end else begin
      state_r <= state_nxt;

      // Take configuration writes
      if (cfg_valid) begin
        if (cfg_index <= ctpm_pkg::REG_OFFSET_CAM4) begin
          for (int i = 0; i < C; i++) begin
            if (cfg_index == 3'(i)) offset_r[i] <= cfg_data;
          end
        end else if (cfg_index == ctpm_pkg::REG_MATCH_WINDOW) begin
          window_r <= cfg_data[15:0];
        end else if (cfg_index == ctpm_pkg::REG_EXPIRY_MARGIN) begin
          margin_r <= cfg_data[19:0];
        end
      end

      unique case (state_r)
        ctpm_pkg::ST_IDLE: begin
          if (in_tvalid) begin
            fall_r      <= prev_trig_r & ~in_tdata[64 +: C];
            prev_trig_r <= in_tdata[64 +: C];
            cur_r       <= in_tdata[31:0];
            if (in_tuser) latch_r <= in_tdata[63:32];
            changed_r   <= in_tuser && (in_tdata[63:32] != latch_r);
            cam_r       <= '0;
            res_cnt_r   <= '0;
          end
        end
        ctpm_pkg::ST_PREP: begin
          k_r <= offset_r[cam_r] - cur_r;
        end
        ctpm_pkg::ST_KADD: begin
          k2_r     <= k_r + {12'd0, margin_r};
          rd_idx_r <= '0;
          w_idx_r  <= '0;
          pv_r     <= 1'b0;
          best_r   <= ctpm_pkg::SEARCH_LIMIT;
          found_r  <= 1'b0;
        end
        ctpm_pkg::ST_SCAN: begin
          // Issue reads, keep the nearest oldest candidate
          pv_r <= rd_go;
          if (pv_r && (mag < {16'd0, best_r})) begin
            best_r     <= mag[15:0];
            best_val_r <= rd_data;
            found_r    <= 1'b1;
          end
          if (pass_done) begin
            rd_idx_r <= '0;
            if (found_r && (best_r < window_r)) begin
              res_r[res_cnt_r[ctpm_pkg::CAM_W-1:0]] <= '{cam: 3'(cam_r), pos: best_val_r};
              res_cnt_r <= res_cnt_r + 1'b1;
            end
          end else begin
            rd_idx_r <= rd_idx_r + ctpm_pkg::CNT_W'(rd_go);
          end
        end
        ctpm_pkg::ST_PURGE: begin
          // Compact the table, dropping the match and expired entries
          pv_r     <= rd_go;
          rd_idx_r <= rd_idx_r + ctpm_pkg::CNT_W'(rd_go);
          if (pv_r && !drop) w_idx_r <= w_idx_r + 1'b1;
          if (pass_done) cnt_r[cam_r] <= w_idx_r;
        end
        ctpm_pkg::ST_APPEND: begin
          if (wr_en) cnt_r[cam_r] <= w_idx_r + 1'b1;
          cam_r  <= last_cam ? '0 : cam_r + 1'b1;
          emit_r <= '0;
        end
        ctpm_pkg::ST_EMIT: begin
          if (out_tready) emit_r <= emit_r + 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Result stream
  assign out_tvalid = (state_r == ctpm_pkg::ST_EMIT);
  assign out_tdata  = {5'd0, res_r[emit_r[ctpm_pkg::CAM_W-1:0]].pos,
                       res_r[emit_r[ctpm_pkg::CAM_W-1:0]].cam};
  assign out_tlast  = (emit_r == res_cnt_r - 1'b1);

  // Checks
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=> !out_tvalid)
    else $error("result after the final one of a poll");
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !out_tvalid)
    else $error("request taken while results pending");
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_cur <= ctpm_pkg::CNT_W'(E))
    else $error("table fill count overflow");
  a_compact: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ctpm_pkg::ST_PURGE) |-> (w_idx_r <= rd_idx_r))
    else $error("purge write overtook read");

endmodule

@@ test/camera_trigger_part_matcher_tb.sv @@
// Testbench for the camera trigger part matcher: directed table, random polls, scoreboard.
module camera_trigger_part_matcher_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT_CYCLES = 400000;
  localparam logic [2:0] REG_OFFSET_CAM1 = 3'd1;
  localparam logic [2:0] REG_OFFSET_CAM2 = 3'd2;
  localparam logic [2:0] REG_OFFSET_CAM3 = 3'd3;
  localparam logic [2:0] REG_UNUSED = 3'd7;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic        out_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  camera_trigger_part_matcher dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  typedef struct {
    logic [2:0]  cam;
    logic [31:0] pos;
    logic        last;
  } match_t;

  typedef struct {
    logic [31:0] enc;
    logic        lseen;
    logic [31:0] lval;
    logic [4:0]  trig;
    int          nexp;  // -1: use predictor only
    match_t      m0;
  } poll_t;

  // Predictor state
  logic [31:0] offs [ctpm_pkg::CAMERAS];
  logic [15:0] window_q;
  logic [19:0] margin_q;
  logic [31:0] parts [ctpm_pkg::CAMERAS][$];
  logic [4:0]  trig_q;
  logic [31:0] latch_q;

  match_t pending_matches [$];
  int errors = 0;
  int n_polls = 0;
  int n_matches = 0;
  int cycles = 0;
  int send_idle = 0;
  int recv_idle = 0;

  function automatic logic [31:0] mag(logic [31:0] d);
    return d[31] ? -d : d;
  endfunction

  // Compute the matches a poll causes and advance the predictor
  task automatic predict_poll(poll_t p);
    logic [31:0] old_l, best, bval, m;
    logic        found;
    int          first;
    logic [31:0] keep [$];
    match_t      nm;
    old_l = latch_q;
    first = pending_matches.size();
    if (p.lseen) latch_q = p.lval;
    for (int c = 0; c < ctpm_pkg::CAMERAS; c++) begin
      if (trig_q[c] && !p.trig[c]) begin
        best = 32'(ctpm_pkg::SEARCH_LIMIT);
        bval = '0;
        found = 1'b0;
        for (int j = 0; j < parts[c].size(); j++) begin
          m = mag(parts[c][j] + offs[c] - p.enc);
          if (m < best) begin
            best = m; bval = parts[c][j]; found = 1'b1;
          end
        end
        if (found) begin
          if (best < {16'd0, window_q}) begin
            nm = '{cam: 3'(c), pos: bval, last: 1'b0};
            pending_matches.insert(pending_matches.size(), nm);
          end
          keep.delete();
          for (int j = 0; j < parts[c].size(); j++)
            if (parts[c][j] != bval) keep.insert(keep.size(), parts[c][j]);
          parts[c] = keep;
        end
      end
    end
    trig_q = p.trig & 5'((1 << ctpm_pkg::CAMERAS) - 1);
    // Drop expired entries
    for (int c = 0; c < ctpm_pkg::CAMERAS; c++) begin
      keep.delete();
      for (int j = 0; j < parts[c].size(); j++) begin
        m = parts[c][j] + offs[c] - p.enc + {12'd0, margin_q};
        if (!m[31]) keep.insert(keep.size(), parts[c][j]);
      end
      parts[c] = keep;
    end
    if (latch_q != old_l)
      for (int c = 0; c < ctpm_pkg::CAMERAS; c++)
        if (parts[c].size() < ctpm_pkg::ENTRIES_PER_CAMERA)
          parts[c].insert(parts[c].size(), latch_q);
    if (pending_matches.size() > first)
      pending_matches[pending_matches.size()-1].last = 1'b1;
    // Cross-check the typed-in expectation of directed rows
    if (p.nexp >= 0) begin
      if (pending_matches.size() - first != p.nexp) begin
        $display("%0t: table row match count expected %0d actual %0d", $realtime,
                 p.nexp, pending_matches.size() - first);
        errors++;
      end else if (p.nexp > 0 && (pending_matches[first].cam != p.m0.cam ||
                   pending_matches[first].pos != p.m0.pos)) begin
        $display("%0t: table row match expected %0d/%h actual %0d/%h", $realtime,
                 p.m0.cam, p.m0.pos, pending_matches[first].cam, pending_matches[first].pos);
        errors++;
      end
    end
  endtask

  // Send one register write request; the caller drops cfg_valid after the last one
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx < ctpm_pkg::CAMERAS) offs[idx] = val;
    else if (idx == ctpm_pkg::REG_MATCH_WINDOW) window_q = val[15:0];
    else if (idx == ctpm_pkg::REG_EXPIRY_MARGIN) margin_q = val[19:0];
  endtask

  // Wait for the block to drain before reconfiguring
  task automatic drain();
    while (pending_matches.size() != 0) @(posedge clk);
    repeat (250) @(posedge clk);
  endtask

  // Send one poll request; the caller drops in_tvalid after the last one
  task automatic send_poll(poll_t p);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {3'd0, p.trig, p.lval, p.enc};
    in_tuser  <= p.lseen;
    do @(posedge clk); while (!in_tready);
    predict_poll(p);
    n_polls++;
  endtask

  function automatic poll_t mk(logic [31:0] e, logic ls, logic [31:0] lv, logic [4:0] t,
                               int n = -1, logic [2:0] c = 0, logic [31:0] pos = 0);
    poll_t p;
    p.enc = e; p.lseen = ls; p.lval = lv; p.trig = t; p.nexp = n;
    p.m0 = '{cam: c, pos: pos, last: 1'b1};
    return p;
  endfunction

  // Compare each result with the oldest expectation
  always @(posedge clk) begin
    match_t e;
    if (rst_n) begin
      out_tready <= ($urandom_range(99) >= recv_idle);
      if (out_tvalid && out_tready) begin
        if (pending_matches.size() == 0) begin
          $display("%0t: unexpected match cam %0d pos %h", $realtime,
                   out_tdata[2:0], out_tdata[34:3]);
          errors++;
        end else begin
          e = pending_matches.pop_front();
          n_matches++;
          if (out_tdata[2:0] != e.cam || out_tdata[34:3] != e.pos || out_tlast != e.last) begin
            $display("%0t: match expected cam %0d pos %h last %b, actual cam %0d pos %h last %b",
                     $realtime, e.cam, e.pos, e.last, out_tdata[2:0], out_tdata[34:3],
                     out_tlast);
            errors++;
          end
        end
      end
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  poll_t dir_table [$];
  logic [31:0] base, lv;
  logic [4:0]  tr;

  initial begin
    for (int c = 0; c < ctpm_pkg::CAMERAS; c++) offs[c] = '0;
    window_q = ctpm_pkg::WINDOW_RESET;
    margin_q = ctpm_pkg::MARGIN_RESET;
    trig_q = '0;
    latch_q = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows at reset settings
    dir_table = '{
      mk(32'd0, 1'b1, 32'd0, 5'h1F, 0),                    // latch unchanged: nothing stored
      mk(32'd0, 1'b0, 32'd0, 5'h00, 0),                    // falls with empty tables
      mk(32'd0, 1'b1, 32'd1000, 5'h01, 0),                 // store 1000
      mk(32'd1000, 1'b0, 32'd0, 5'h00, 1, 3'd0, 32'd1000), // exact hit on camera 0
      mk(32'd1000, 1'b1, 32'h7FFFFFFF, 5'h1F, 0),
      mk(32'h7FFFFFFF, 1'b1, 32'h80000000, 5'h1F, 0),
      mk(32'h80000000, 1'b1, 32'h80000000, 5'h1E, 1, 3'd0, 32'h80000000),
      mk(32'h80000000, 1'b1, 32'h00000000, 5'h1F, 0),      // far entry
      mk(32'h80000000, 1'b0, 32'd0, 5'h00, -1),            // extreme distance
      mk(32'd0, 1'b1, 32'd100, 5'h02, 0),
      mk(32'd4999, 1'b1, 32'd100, 5'h00, 0),               // distance 4899 matches? check pred
      mk(32'd0, 1'b1, 32'd200, 5'h04, 0),
      mk(32'd5200, 1'b0, 32'd0, 5'h00, -1),                // outside window: erase, no match
      mk(32'd0, 1'b1, 32'hFFFFFFFF, 5'h1F, 0),
      mk(32'hFFFFFFFF, 1'b1, 32'h12345678, 5'h1F, -1),
      mk(32'h12345678, 1'b0, 32'd0, 5'h00, -1)             // several cameras at once
    };
    dir_table[10].nexp = -1;
    foreach (dir_table[i]) send_poll(dir_table[i]);
    in_tvalid <= 1'b0;

    // Fill a table past capacity, equal values, unused register index
    drain();
    write_reg(REG_UNUSED, 32'hFFFFFFFF);
    write_reg(ctpm_pkg::REG_EXPIRY_MARGIN, 32'hFFFFF);
    cfg_valid <= 1'b0;
    for (int i = 0; i < 20; i++) send_poll(mk(32'd0, 1'b1, 32'(i % 2 ? 7 : 3), 5'h1F));
    send_poll(mk(32'd5, 1'b0, 32'd0, 5'h00));
    in_tvalid <= 1'b0;

    // Pause until every match has come
    while (pending_matches.size() != 0) @(posedge clk);

    // Random phases with different settings and idling
    for (int ph = 0; ph < 3; ph++) begin
      drain();
      send_idle = (ph == 0) ? 11 : (ph == 1) ? 53 : 0;
      recv_idle = (ph == 0) ? 53 : (ph == 1) ? 11 : 0;
      write_reg(ctpm_pkg::REG_OFFSET_CAM0, (ph == 2) ? 32'h80000000 : $urandom_range(20000));
      write_reg(REG_OFFSET_CAM1, (ph == 2) ? 32'h7FFFFFFF : $urandom_range(20000));
      write_reg(REG_OFFSET_CAM2, $urandom_range(20000));
      write_reg(REG_OFFSET_CAM3, $urandom);
      write_reg(ctpm_pkg::REG_OFFSET_CAM4, -$urandom_range(20000));
      write_reg(ctpm_pkg::REG_MATCH_WINDOW,
                (ph == 0) ? 32'd60000 : (ph == 1) ? 32'd0 : 32'd4000);
      write_reg(ctpm_pkg::REG_EXPIRY_MARGIN, (ph == 1) ? 32'd0 : $urandom_range(1000000));
      cfg_valid <= 1'b0;
      base = (ph == 2) ? 32'h7FFF0000 : $urandom;
      tr = '0;
      lv = base;
      for (int i = 0; i < 30; i++) begin
        if ($urandom_range(9) == 0) base = $urandom;   // noise jump
        else base = base + $urandom_range(3000);
        if ($urandom_range(2) == 0) lv = base - $urandom_range(2000);
        tr = 5'($urandom);
        send_poll(mk(base, 1'($urandom), ($urandom_range(7) == 0) ? $urandom : lv, tr));
      end
      in_tvalid <= 1'b0;
    end

    while (pending_matches.size() != 0) @(posedge clk);
    repeat (250) @(posedge clk);
    $display("Covered %0d polls and %0d matches over three register settings,", n_polls,
             n_matches);
    $display("with full tables, wrapped positions and both sides idling.");
    if (errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
